// File: rtl/core/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// shared types and constants of the lru page replacement unit
// ----------------------------------------------------------------------------
package lru_pkg;

	// configuration register and result field widths
	localparam int CFG_W         = 6;
	localparam int FRAME_INDEX_W = 5;
	localparam int HIT_W         = 16;

	// frames_in_use after reset
	localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 6'd8;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_UPD  = 3'b100
	} lru_state_t;

	// control broadcast from the sequencer to every frame cell
	typedef struct packed {
		logic clear;   // configuration write: drop every frame
		logic look;    // compare cycle: latch per-cell flags
		logic update;  // update cycle: write target, age the others
		logic full;    // every active frame holds a page
		logic hit;     // registered hit of the current transaction
	} lru_ctl_t;

endpackage

// File: rtl/core/lru_frame_cell.sv
// ----------------------------------------------------------------------------
// lru_frame_cell
// one page frame: page, valid, recency rank and the link to its neighbor
// ----------------------------------------------------------------------------
module lru_frame_cell import lru_pkg::*; #(
	parameter int MAX_FRAMES = 32,
	parameter int PAGE_BITS  = 16,
	parameter int IDX        = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lru_ctl_t                             ctl,
	input  logic [PAGE_BITS-1:0]                 page,
	input  logic [$clog2(MAX_FRAMES+1)-1:0]      count,
	input  logic [$clog2(MAX_FRAMES+1)-1:0]      last_rank,
	input  logic [$clog2(MAX_FRAMES+1)-1:0]      limit,
	// chain from the lower neighbor
	input  logic                                 hit_i,
	input  logic [$clog2(MAX_FRAMES)-1:0]        hit_rank_i,
	input  logic [$clog2(MAX_FRAMES)-1:0]        hit_idx_i,
	input  logic [$clog2(MAX_FRAMES)-1:0]        miss_idx_i,
	input  logic [PAGE_BITS-1:0]                 ev_page_i,
	// chain to the upper neighbor
	output logic                                 hit_o,
	output logic [$clog2(MAX_FRAMES)-1:0]        hit_rank_o,
	output logic [$clog2(MAX_FRAMES)-1:0]        hit_idx_o,
	output logic [$clog2(MAX_FRAMES)-1:0]        miss_idx_o,
	output logic [PAGE_BITS-1:0]                 ev_page_o
);

	localparam int RANK_W = $clog2(MAX_FRAMES);
	localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
	localparam logic [CNT_W-1:0]  IDX_CNT = CNT_W'(IDX);
	localparam logic [RANK_W-1:0] IDX_SEL = RANK_W'(IDX);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [RANK_W-1:0]    rank_q;
	logic                 match_q;
	logic                 fill_q;
	logic                 evict_q;

	logic match;
	logic fill;
	logic evict;
	logic target;

	assign match  = valid_q && (page_q == page);
	assign fill   = !ctl.full && (count == IDX_CNT);
	assign evict  = ctl.full && valid_q && (CNT_W'(rank_q) == last_rank);
	assign target = match_q || (!ctl.hit && (fill_q || evict_q));

	// neighbor chain: at most one cell contributes to each field
	assign hit_o      = hit_i | match;
	assign hit_rank_o = hit_rank_i | (match ? rank_q : '0);
	assign hit_idx_o  = hit_idx_i | (match ? IDX_SEL : '0);
	assign miss_idx_o = miss_idx_i | ((fill || evict) ? IDX_SEL : '0);
	assign ev_page_o  = ev_page_i | (evict ? page_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
			match_q <= 1'b0;
			fill_q  <= 1'b0;
			evict_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (ctl.look) begin
			match_q <= match;
			fill_q  <= fill;
			evict_q <= evict;
		end else if (ctl.update) begin
			if (target) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (valid_q && (CNT_W'(rank_q) < limit)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			page_q <= '0;
		end else if (ctl.update && target) begin
			page_q <= page;
		end
	end

endmodule

// File: rtl/core/lru_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// fully associative lru page-frame store built as a row of frame cells
// ----------------------------------------------------------------------------
// Each input transaction carries one page number and returns one result
// transaction. Inside the block a transaction passes a look cycle, in which
// every frame cell compares its page at once and the hit, the hit rank, the
// frame chosen on a miss and the page to evict ripple from cell to cell along
// the row, and an update cycle, in which the target cell takes the page with
// rank 0 and the other valid cells age. The result lands in an output
// register, so the next page is taken in the update cycle while the output
// side keeps up; a stalled result holds the update cycle until the register
// frees. Valid frames always form a prefix of the row, so the first empty
// frame is the one at the fill count, and the frame to evict is the one whose
// rank is frames in use minus one. Writing frames_in_use (0 acts as 1, values
// above MAX_FRAMES act as MAX_FRAMES) drops every frame in that same cycle;
// the hit count is kept.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit import lru_pkg::*; #(
	parameter int MAX_FRAMES = 32,
	parameter int PAGE_BITS  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write
	input  logic                     cfg_wr_en,
	input  logic [CFG_W-1:0]         cfg_wr_data,
	// input transactions
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [PAGE_BITS-1:0]     page_number,
	// result transactions
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic [FRAME_INDEX_W-1:0] frame_index,
	output logic                     evicted_valid,
	output logic [PAGE_BITS-1:0]     evicted_page,
	output logic [HIT_W-1:0]         hit_total
);

	localparam int RANK_W = $clog2(MAX_FRAMES);
	localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAMES);

	// clamp a frames_in_use value to 1..MAX_FRAMES
	function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] v);
		logic [CMP_W-1:0] w;
		logic [CMP_W-1:0] r;
		begin
			w = CMP_W'(v);
			if (w == '0) begin
				r = CMP_W'(1);
			end else if (w > MAX_CMP) begin
				r = MAX_CMP;
			end else begin
				r = w;
			end
			return CNT_W'(r);
		end
	endfunction

	lru_state_t state_q;

	logic [CNT_W-1:0]     n_q;      // active frames
	logic [CNT_W-1:0]     count_q;  // valid frames, always a prefix of the row
	logic [PAGE_BITS-1:0] page_q;
	logic [HIT_W-1:0]     hit_cnt_q;

	// look cycle results
	logic                 hit_s1;
	logic [RANK_W-1:0]    hit_rank_s1;
	logic [RANK_W-1:0]    hit_idx_s1;
	logic [RANK_W-1:0]    miss_idx_s1;
	logic [PAGE_BITS-1:0] ev_page_s1;

	// output register
	logic                     out_valid_q;
	logic                     hit_q;
	logic [FRAME_INDEX_W-1:0] frame_index_q;
	logic                     evicted_valid_q;
	logic [PAGE_BITS-1:0]     evicted_page_q;
	logic [HIT_W-1:0]         hit_total_q;

	logic             can_finish;
	logic             in_take;
	logic             full;
	logic [CNT_W-1:0] last_rank;
	logic [CNT_W-1:0] limit;
	logic [HIT_W-1:0] hit_cnt_next;
	logic             ev_valid;
	lru_ctl_t         ctl;

	// neighbor chain between the cells
	logic                 ch_hit      [MAX_FRAMES+1];
	logic [RANK_W-1:0]    ch_hit_rank [MAX_FRAMES+1];
	logic [RANK_W-1:0]    ch_hit_idx  [MAX_FRAMES+1];
	logic [RANK_W-1:0]    ch_miss_idx [MAX_FRAMES+1];
	logic [PAGE_BITS-1:0] ch_ev_page  [MAX_FRAMES+1];

	// update cycle may retire when the output register is free or draining
	assign can_finish = !out_valid_q || !out_stall;
	assign in_stall   = !((state_q == ST_IDLE) || ((state_q == ST_UPD) && can_finish));
	assign in_take    = in_valid && !in_stall;

	assign full      = (count_q == n_q);
	assign last_rank = n_q - 1'b1;

	// ranks below the limit age by one
	always_comb begin
		if (hit_s1) begin
			limit = CNT_W'(hit_rank_s1);
		end else if (full) begin
			limit = last_rank;
		end else begin
			limit = count_q;
		end
	end

	assign ev_valid     = !hit_s1 && full;
	assign hit_cnt_next = (hit_s1 && (hit_cnt_q != '1)) ? hit_cnt_q + 1'b1 : hit_cnt_q;

	always_comb begin
		ctl.clear  = cfg_wr_en;
		ctl.look   = (state_q == ST_LOOK);
		ctl.update = (state_q == ST_UPD) && can_finish;
		ctl.full   = full;
		ctl.hit    = hit_s1;
	end

	// chain head
	assign ch_hit[0]      = 1'b0;
	assign ch_hit_rank[0] = '0;
	assign ch_hit_idx[0]  = '0;
	assign ch_miss_idx[0] = '0;
	assign ch_ev_page[0]  = '0;

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		lru_frame_cell #(
			.MAX_FRAMES (MAX_FRAMES),
			.PAGE_BITS  (PAGE_BITS),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.page       (page_q),
			.count      (count_q),
			.last_rank  (last_rank),
			.limit      (limit),
			.hit_i      (ch_hit[i]),
			.hit_rank_i (ch_hit_rank[i]),
			.hit_idx_i  (ch_hit_idx[i]),
			.miss_idx_i (ch_miss_idx[i]),
			.ev_page_i  (ch_ev_page[i]),
			.hit_o      (ch_hit[i+1]),
			.hit_rank_o (ch_hit_rank[i+1]),
			.hit_idx_o  (ch_hit_idx[i+1]),
			.miss_idx_o (ch_miss_idx[i+1]),
			.ev_page_o  (ch_ev_page[i+1])
		);
	end

	// sequencer, frame count and hit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= active_count(CFG_FRAMES_RESET);
			count_q   <= '0;
			hit_cnt_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				n_q     <= active_count(cfg_wr_data);
				count_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (can_finish) begin
						hit_cnt_q <= hit_cnt_next;
						if (!hit_s1 && !full) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= in_take ? ST_LOOK : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// page of the transaction in flight
	always_ff @(posedge clk) begin
		if (in_take) begin
			page_q <= page_number;
		end
	end

	// end of the chain, captured in the look cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (ctl.look) begin
			hit_s1 <= ch_hit[MAX_FRAMES];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.look) begin
			hit_rank_s1 <= ch_hit_rank[MAX_FRAMES];
			hit_idx_s1  <= ch_hit_idx[MAX_FRAMES];
			miss_idx_s1 <= ch_miss_idx[MAX_FRAMES];
			ev_page_s1  <= ch_ev_page[MAX_FRAMES];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.update) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.update) begin
			hit_q           <= hit_s1;
			frame_index_q   <= FRAME_INDEX_W'(hit_s1 ? hit_idx_s1 : miss_idx_s1);
			evicted_valid_q <= ev_valid;
			evicted_page_q  <= ev_valid ? ev_page_s1 : '0;
			hit_total_q     <= hit_cnt_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign hit_total     = hit_total_q;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the lru page replacement unit
// ----------------------------------------------------------------------------
// A directed table runs first. It covers the reset frame count, the extreme
// page numbers, fill, hit, eviction and the frame count extremes. Random
// phases follow, each under its own frames_in_use setting, and a last phase
// sends back to back accesses into a single frame. Every accepted page goes
// through a local lru predictor. Each result transaction is checked field by
// field against the oldest pending expectation. The sender works in bursts and
// the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
	import lru_pkg::*;

	localparam int FRAMES_MAX  = 32;
	localparam int PAGE_W      = 16;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int REPORT_MAX  = 40;

	typedef struct packed {
		logic                     hit;
		logic [FRAME_INDEX_W-1:0] frame;
		logic                     ev_valid;
		logic [PAGE_W-1:0]        ev_page;
		logic [HIT_W-1:0]         hit_total;
	} access_result_t;

	typedef enum logic {
		ROW_ACCESS,
		ROW_CONFIG
	} row_kind_e;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPARSE,
		STALL_HEAVY,
		STALL_RUNS
	} stall_mode_e;

	// one row of the directed part: a page access or a frames_in_use write
	typedef struct packed {
		row_kind_e         kind;
		logic [PAGE_W-1:0] value;
		logic              typed;   // want holds a hand-written result
		access_result_t    want;
	} dir_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]         cfg_wr_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [PAGE_W-1:0]        page_number = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     hit;
	logic [FRAME_INDEX_W-1:0] frame_index;
	logic                     evicted_valid;
	logic [PAGE_W-1:0]        evicted_page;
	logic [HIT_W-1:0]         hit_total;

	// hand-written expectation that travels with the page on the input side
	logic           want_typed = 1'b0;
	access_result_t want_fixed = '0;

	// predictor copy of the frame store
	logic [PAGE_W-1:0]        page_of [FRAMES_MAX];
	bit                       held    [FRAMES_MAX];
	logic [FRAME_INDEX_W-1:0] rank_of [FRAMES_MAX];
	logic [HIT_W-1:0]         hits_seen;
	logic [CFG_W-1:0]         frames_cfg;

	access_result_t pending_results [$];
	int             mismatch_count = 0;
	int             items_sent = 0;
	int             results_seen = 0;
	int             cycles = 0;
	int             burst_left = 0;
	bit             quiet = 1'b0;

	// directed rows, reset frame count of 8 in force at the start
	// typed rows are the ones that can be read off by hand
	dir_row_t dir_rows [26] = '{
		// first fill after reset, both page extremes
		'{ROW_ACCESS, 16'h0000, 1'b1, '{1'b0, 5'd0, 1'b0, 16'h0000, 16'd0}},
		'{ROW_ACCESS, 16'hFFFF, 1'b1, '{1'b0, 5'd1, 1'b0, 16'h0000, 16'd0}},
		'{ROW_ACCESS, 16'h0000, 1'b1, '{1'b1, 5'd0, 1'b0, 16'h0000, 16'd1}},
		'{ROW_ACCESS, 16'hFFFF, 1'b1, '{1'b1, 5'd1, 1'b0, 16'h0000, 16'd2}},
		// fill the remaining six of eight frames
		'{ROW_ACCESS, 16'h0001, 1'b0, '0},
		'{ROW_ACCESS, 16'h0002, 1'b0, '0},
		'{ROW_ACCESS, 16'h0003, 1'b0, '0},
		'{ROW_ACCESS, 16'h0004, 1'b0, '0},
		'{ROW_ACCESS, 16'h0005, 1'b0, '0},
		'{ROW_ACCESS, 16'h0006, 1'b0, '0},
		// all frames full: page 0 in frame 0 is the oldest
		'{ROW_ACCESS, 16'h0007, 1'b1, '{1'b0, 5'd0, 1'b1, 16'h0000, 16'd2}},
		'{ROW_ACCESS, 16'hFFFF, 1'b0, '0},
		// zero frames acts as one, hit count survives the write
		'{ROW_CONFIG, 16'h0000, 1'b0, '0},
		'{ROW_ACCESS, 16'h1234, 1'b1, '{1'b0, 5'd0, 1'b0, 16'h0000, 16'd3}},
		'{ROW_ACCESS, 16'h1234, 1'b1, '{1'b1, 5'd0, 1'b0, 16'h0000, 16'd4}},
		'{ROW_ACCESS, 16'hABCD, 1'b1, '{1'b0, 5'd0, 1'b1, 16'h1234, 16'd4}},
		// frame count above the maximum is clamped, store starts empty
		'{ROW_CONFIG, 16'h003F, 1'b0, '0},
		'{ROW_ACCESS, 16'hFFFF, 1'b1, '{1'b0, 5'd0, 1'b0, 16'h0000, 16'd4}},
		'{ROW_ACCESS, 16'h0000, 1'b1, '{1'b0, 5'd1, 1'b0, 16'h0000, 16'd4}},
		'{ROW_ACCESS, 16'hFFFF, 1'b0, '0},
		'{ROW_CONFIG, 16'h0001, 1'b0, '0},
		'{ROW_ACCESS, 16'h5A5A, 1'b0, '0},
		'{ROW_ACCESS, 16'hA5A5, 1'b0, '0},
		'{ROW_CONFIG, 16'h0020, 1'b0, '0},
		'{ROW_ACCESS, 16'h8000, 1'b0, '0},
		'{ROW_ACCESS, 16'h7FFF, 1'b0, '0}
	};

	lru_page_replacement_unit #(
		.MAX_FRAMES (FRAMES_MAX),
		.PAGE_BITS  (PAGE_W)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.page_number   (page_number),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.hit_total     (hit_total)
	);

	always #4 clk = ~clk;

	// frames_in_use write: every frame dropped, hit count kept
	function automatic void apply_frames_write(input logic [CFG_W-1:0] v);
		frames_cfg = v;
		for (int i = 0; i < FRAMES_MAX; i++) begin
			page_of[i] = '0;
			held[i]    = 1'b0;
			rank_of[i] = '0;
		end
	endfunction

	// one page access through the lru store, returns the result transaction
	function automatic access_result_t lru_access(input logic [PAGE_W-1:0] pg);
		access_result_t r;
		int n, cnt, tgt, lim;
		bit found;
		r = '0;
		// zero acts as one, anything above the maximum acts as the maximum
		n = (frames_cfg == 0) ? 1 :
			((int'(frames_cfg) > FRAMES_MAX) ? FRAMES_MAX : int'(frames_cfg));
		cnt = 0;
		tgt = 0;
		lim = 0;
		found = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (held[i]) begin
				cnt++;
				if (!r.hit && page_of[i] == pg) begin
					r.hit = 1'b1;
					tgt = i;
				end
			end
		end
		if (r.hit) begin
			lim = int'(rank_of[tgt]);
			if (hits_seen != '1)
				hits_seen++;
		end else begin
			// lowest empty frame wins, so scan from the top down
			for (int i = n - 1; i >= 0; i--) begin
				if (!held[i]) begin
					tgt = i;
					found = 1'b1;
				end
			end
			if (found) begin
				lim = cnt;
			end else begin
				// oldest frame holds the highest rank
				tgt = 0;
				for (int i = 1; i < n; i++) begin
					if (rank_of[i] > rank_of[tgt])
						tgt = i;
				end
				r.ev_valid = 1'b1;
				r.ev_page  = page_of[tgt];
				lim = int'(rank_of[tgt]);
			end
		end
		for (int i = 0; i < n; i++) begin
			if (i != tgt && held[i] && int'(rank_of[i]) < lim)
				rank_of[i]++;
		end
		page_of[tgt] = pg;
		held[tgt]    = 1'b1;
		rank_of[tgt] = '0;
		r.frame     = FRAME_INDEX_W'(tgt);
		r.hit_total = hits_seen;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatch_count < REPORT_MAX)
			$display("%0t mismatch in %s: got %h expected %h (result %0d)",
				$realtime, what, got, want, results_seen);
		mismatch_count++;
	endtask

	// send one page; bursts of random length with random gaps in between
	task automatic drive_access(input logic [PAGE_W-1:0] pg, input logic typed,
			input access_result_t want);
		int gap;
		gap = 0;
		if (!quiet) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
			burst_left--;
		end
		if (gap > 0) begin
			in_valid    <= 1'b0;
			page_number <= PAGE_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		page_number <= pg;
		want_typed  <= typed;
		want_fixed  <= want;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// write frames_in_use once the block has drained
	task automatic write_frames(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= CFG_W'($urandom);
	endtask

	// receiver stall pattern, switching between random modes
	always @(posedge clk) begin : stall_gen
		static stall_mode_e mode = STALL_NONE;
		static int span = 0;
		static int run_left = 0;
		if (span == 0) begin
			mode = stall_mode_e'($urandom_range(0, 3));
			span = $urandom_range(30, 120);
		end else begin
			span--;
		end
		if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			case (mode)
				STALL_NONE: begin
					out_stall <= 1'b0;
				end
				STALL_SPARSE: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				STALL_HEAVY: begin
					out_stall <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					// long stretches held high
					if (run_left > 0) begin
						run_left--;
						out_stall <= 1'b1;
					end else begin
						if ($urandom_range(0, 5) == 0)
							run_left = $urandom_range(2, 10);
						out_stall <= 1'b0;
					end
				end
			endcase
		end
	end

	// both sides sampled on the same edge: predict on input, check on output
	always @(posedge clk) begin : scoreboard
		access_result_t predicted, exp_r;
		if (arst_n) begin
			if (cfg_wr_en)
				apply_frames_write(cfg_wr_data);
			if (in_valid && !in_stall) begin
				predicted = lru_access(page_number);
				pending_results.insert(pending_results.size(),
					want_typed ? want_fixed : predicted);
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", 16'(frame_index), 16'd0);
				end else begin
					exp_r = pending_results[0];
					pending_results.delete(0);
					if (hit !== exp_r.hit)
						report_mismatch("hit", 16'(hit), 16'(exp_r.hit));
					if (frame_index !== exp_r.frame)
						report_mismatch("frame_index", 16'(frame_index), 16'(exp_r.frame));
					if (evicted_valid !== exp_r.ev_valid)
						report_mismatch("evicted_valid", 16'(evicted_valid),
							16'(exp_r.ev_valid));
					if (evicted_page !== exp_r.ev_page)
						report_mismatch("evicted_page", evicted_page, exp_r.ev_page);
					if (hit_total !== exp_r.hit_total)
						report_mismatch("hit_total", hit_total, exp_r.hit_total);
				end
				results_seen++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [PAGE_W-1:0] pool [48];
		logic [CFG_W-1:0]  v;
		int eff, pool_n, n_items;
		hits_seen = '0;
		apply_frames_write(CFG_FRAMES_RESET);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part
		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CONFIG)
				write_frames(dir_rows[k].value[CFG_W-1:0]);
			else
				drive_access(dir_rows[k].value, dir_rows[k].typed, dir_rows[k].want);
		end

		// random phases, one frame count setting each
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: v = 6'd1;
				1: v = 6'd32;
				2: v = 6'd63;
				3: v = 6'd0;
				4: v = CFG_W'($urandom_range(2, 31));
				5: v = CFG_W'($urandom_range(33, 62));
				6: v = 6'd4;
				7: v = 6'd8;
				default: v = CFG_W'($urandom_range(0, 63));
			endcase
			write_frames(v);
			eff = (v == 0) ? 1 : ((int'(v) > FRAMES_MAX) ? FRAMES_MAX : int'(v));
			// working set a little larger than the store: hits and evictions mix
			pool_n = eff + $urandom_range(1, 6);
			if (pool_n > 48)
				pool_n = 48;
			foreach (pool[i])
				pool[i] = PAGE_W'($urandom);
			n_items = (eff > 16) ? $urandom_range(45, 60) : $urandom_range(28, 38);
			for (int k = 0; k < n_items; k++) begin
				if ($urandom_range(0, 99) < 85)
					drive_access(pool[$urandom_range(0, pool_n - 1)], 1'b0, '0);
				else
					drive_access(PAGE_W'($urandom), 1'b0, '0);
			end
		end

		// single frame: back to back hits with no idling, then mixed traffic
		write_frames(6'd1);
		quiet = 1'b1;
		for (int k = 0; k < 16; k++)
			drive_access(16'hBEEF, 1'b0, '0);
		quiet = 1'b0;
		for (int k = 0; k < 20; k++)
			drive_access(($urandom_range(0, 1) == 0) ? 16'hBEEF : 16'h0BAD, 1'b0, '0);

		// drain
		in_valid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
		repeat (16) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", 16'd0, 16'(pending_results.size()));

		if (mismatch_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
